// File: design/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared widths and operation/status codes of the gap-buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

	localparam int KIND_W   = 3;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 11;
	localparam int OFFSET_W = 12;
	localparam int RIDX_W   = 10;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 11;   // cursor / length port width

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam kind_t KIND_INSERT  = 3'd0;
	localparam kind_t KIND_DEL_L   = 3'd1;
	localparam kind_t KIND_DEL_R   = 3'd2;
	localparam kind_t KIND_MOVE    = 3'd3;
	localparam kind_t KIND_READ    = 3'd4;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_FULL       = 2'd1;
	localparam status_t ST_MOVE_RANGE = 2'd2;
	localparam status_t ST_READ_RANGE = 2'd3;

endpackage

// File: design/gbts_ram.sv
// ----------------------------------------------------------------------------
// gbts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/gap_buffer_text_store_core.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// Gap-buffer text store: insert, delete left/right, move gap, read by index.
// ----------------------------------------------------------------------------
// Timing: insert, deletes and rejected ops show done in the cycle after accept;
//   an in-range read passes through ST_RD (one RAM read) and a gap move through
//   ST_MOVE, one byte copied per cycle through the single RAM read/write port pair.
// busy is high only while a read or move is in flight; a new request is taken
//   in the same cycle a result is shown. The receiver cannot stall results.
// Reset: cursor 0, length 0 (gap spans the whole store); the RAM contents are
//   not cleared, nothing reads a byte that was never written.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_core #(
	parameter int CAPACITY = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [gbts_pkg::KIND_W-1:0]             kind,
	input  logic [gbts_pkg::BYTE_W-1:0]             data_byte,
	input  logic [gbts_pkg::COUNT_W-1:0]            count,
	input  logic signed [gbts_pkg::OFFSET_W-1:0]    offset,
	input  logic [gbts_pkg::RIDX_W-1:0]             read_index,
	output logic                                    done,
	output logic [gbts_pkg::STATUS_W-1:0]           status,
	output logic [gbts_pkg::BYTE_W-1:0]             read_byte,
	output logic [gbts_pkg::POS_W-1:0]              cursor,
	output logic [gbts_pkg::POS_W-1:0]              length
);

	// address / pointer widths
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	// working width for compares: holds pointers, count, offset, index + sign
	localparam int WW = (PW > gbts_pkg::OFFSET_W ? PW : gbts_pkg::OFFSET_W) + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_MOVE
	} state_t;

	state_t                       state_q;
	logic [PW-1:0]                gs_q;       // gap start (cursor)
	logic [PW-1:0]                ge_q;       // gap end
	logic                         done_q;
	gbts_pkg::status_t            status_q;
	logic [gbts_pkg::BYTE_W-1:0]  rbyte_q;

	// move engine
	logic                         dir_fwd_q;
	logic [AW-1:0]                src_q;
	logic [AW-1:0]                dst_q;
	logic [PW-1:0]                rem_q;
	logic                         v_s1;       // read in flight, write next cycle
	logic [AW-1:0]                dst_s1;

	// RAM port
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [gbts_pkg::BYTE_W-1:0]  ram_wdata;
	logic                         ram_re;
	logic [AW-1:0]                ram_raddr;
	logic [gbts_pkg::BYTE_W-1:0]  ram_rdata;

	// --------------------------------------------------------------------
	// Per-request arithmetic, all in WW bits
	// --------------------------------------------------------------------
	logic                         accept;
	logic [WW-1:0]                gs_w, ge_w, cap_w, gap_w, len_w;
	logic [WW-1:0]                cnt_w, ridx_w, avail_r, phys_w;
	logic signed [WW-1:0]         off_s, ns_s, ne_s;
	logic [WW-1:0]                mag_w;
	logic                         move_noop, move_bad, rd_ok;

	assign accept = start && !busy;

	always_comb begin
		gs_w    = WW'(gs_q);
		ge_w    = WW'(ge_q);
		cap_w   = WW'(CAPACITY);
		gap_w   = ge_w - gs_w;
		len_w   = cap_w - gap_w;
		cnt_w   = WW'(count);
		ridx_w  = WW'(read_index);
		avail_r = cap_w - ge_w;
		// logical index maps past the gap once it reaches the cursor
		phys_w  = (ridx_w < gs_w) ? ridx_w : ridx_w + gap_w;
		rd_ok   = ridx_w < len_w;
		off_s   = WW'(offset);
		ns_s    = signed'(gs_w) + off_s;
		ne_s    = signed'(ge_w) + off_s;
		mag_w   = (off_s < 0) ? WW'(-off_s) : WW'(off_s);
		move_noop = (off_s == '0) || (len_w == '0);
		move_bad  = (ns_s < 0) || (ne_s > signed'(cap_w));
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign read_byte = rbyte_q;
	assign cursor    = gs_w[gbts_pkg::POS_W-1:0];
	assign length    = len_w[gbts_pkg::POS_W-1:0];

	// --------------------------------------------------------------------
	// RAM access steering
	// Idle: insert writes at the cursor, read issues the physical address.
	// Move: read the source while bytes remain, write the byte fetched the cycle before.
	// Source and destination ranges of a move never alias in flight.
	// --------------------------------------------------------------------
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = gs_q[AW-1:0];
		ram_wdata = data_byte;
		ram_re    = 1'b0;
		ram_raddr = phys_w[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == gbts_pkg::KIND_INSERT && gs_q < ge_q) begin
					ram_we = 1'b1;
				end
				if (accept && kind == gbts_pkg::KIND_READ && rd_ok) begin
					ram_re = 1'b1;
				end
			end
			ST_MOVE: begin
				ram_we    = v_s1;
				ram_waddr = dst_s1;
				ram_wdata = ram_rdata;
				ram_re    = (rem_q != '0);
				ram_raddr = src_q;
			end
			default: begin
			end
		endcase
	end

	gbts_ram #(
		.WIDTH (gbts_pkg::BYTE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// --------------------------------------------------------------------
	// Control FSM, pointers and registered results
	// Pointers take their final value at accept; the move engine then
	// copies the bytes the gap passes over.
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gs_q      <= '0;
			ge_q      <= PW'(CAPACITY);
			done_q    <= 1'b0;
			status_q  <= gbts_pkg::ST_OK;
			rbyte_q   <= '0;
			dir_fwd_q <= 1'b0;
			src_q     <= '0;
			dst_q     <= '0;
			rem_q     <= '0;
			v_s1      <= 1'b0;
			dst_s1    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= gbts_pkg::ST_OK;
						rbyte_q  <= '0;
						done_q   <= 1'b1;
						case (kind)
							gbts_pkg::KIND_INSERT: begin
								if (gs_q < ge_q) begin
									gs_q <= gs_q + PW'(1);
								end else begin
									status_q <= gbts_pkg::ST_FULL;
								end
							end
							gbts_pkg::KIND_DEL_L: begin
								gs_q <= (cnt_w > gs_w) ? '0 : PW'(gs_w - cnt_w);
							end
							gbts_pkg::KIND_DEL_R: begin
								ge_q <= (cnt_w > avail_r) ? PW'(CAPACITY) : PW'(ge_w + cnt_w);
							end
							gbts_pkg::KIND_MOVE: begin
								if (!move_noop) begin
									if (move_bad) begin
										status_q <= gbts_pkg::ST_MOVE_RANGE;
									end else begin
										gs_q      <= PW'(ns_s);
										ge_q      <= PW'(ne_s);
										rem_q     <= PW'(mag_w);
										dir_fwd_q <= (off_s > 0);
										// forward: copy from above the gap down
										// backward: copy from below the gap up,
										// highest byte first
										if (off_s > 0) begin
											src_q <= ge_w[AW-1:0];
											dst_q <= gs_w[AW-1:0];
										end else begin
											src_q <= AW'(gs_w - WW'(1));
											dst_q <= AW'(ge_w - WW'(1));
										end
										done_q  <= 1'b0;
										state_q <= ST_MOVE;
									end
								end
							end
							gbts_pkg::KIND_READ: begin
								if (rd_ok) begin
									done_q  <= 1'b0;
									state_q <= ST_RD;
								end else begin
									status_q <= gbts_pkg::ST_READ_RANGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					rbyte_q <= ram_rdata;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_MOVE: begin
					v_s1   <= (rem_q != '0);
					dst_s1 <= dst_q;
					if (rem_q != '0) begin
						rem_q <= rem_q - PW'(1);
						if (dir_fwd_q) begin
							src_q <= src_q + AW'(1);
							dst_q <= dst_q + AW'(1);
						end else begin
							src_q <= src_q - AW'(1);
							dst_q <= dst_q - AW'(1);
						end
					end else begin
						// last byte written this cycle
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// --------------------------------------------------------------------
	// Assertions
	// --------------------------------------------------------------------
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gs_q <= ge_q)
		else $error("gap start passed gap end");

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ge_q <= PW'(CAPACITY))
		else $error("gap end beyond capacity");

	a_move_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |-> (rem_q != '0 || v_s1))
		else $error("move engine stalled with nothing to do");

	a_rd_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> !ram_we)
		else $error("RAM written while a read request is pending");

	a_move_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE && rem_q == '0) |=> (done_q && state_q == ST_IDLE))
		else $error("move did not complete after last copy");

endmodule
